[src/mpst_pkg.sv]
`default_nettype none

package mpst_pkg;

	localparam int POS_W  = 10;
	localparam int VAL_W  = 40;
	localparam int COST_W = 61;
	// raw join sums: up to three terms of at most 2^60 each
	localparam int SUM_W  = 62;

	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 40;

	localparam logic [COST_W-1:0] INF_COST = COST_W'(64'd1 << 60);

	// cost index is {left end state, right end state}
	typedef struct packed {
		logic [3:0][COST_W-1:0] cost;
		logic [VAL_W-1:0]       link;
	} node_t;

	localparam node_t PAD_NODE = '{
		cost: {{COST_W{1'b0}}, INF_COST, INF_COST, {COST_W{1'b0}}},
		link: {VAL_W{1'b0}}
	};

	// minimum of four sums, capped at infinity
	function automatic logic [SUM_W-1:0] cost_min4(
		input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b,
		input logic [SUM_W-1:0] c,
		input logic [SUM_W-1:0] d
	);
		logic [SUM_W-1:0] m_ab;
		logic [SUM_W-1:0] m_cd;
		logic [SUM_W-1:0] m;
		m_ab = (a < b) ? a : b;
		m_cd = (c < d) ? c : d;
		m    = (m_ab < m_cd) ? m_ab : m_cd;
		if (m > {1'b0, INF_COST}) begin
			m = {1'b0, INF_COST};
		end
		return m;
	endfunction

endpackage

`default_nettype wire

[src/mpst_ram.sv]
`default_nettype none

module mpst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/mpst_join.sv]
`default_nettype none

// Min-plus join of two nodes, two stages: raw sums registered, then min and cap.
module mpst_join (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire mpst_pkg::node_t left,
	input  wire mpst_pkg::node_t right,
	output mpst_pkg::node_t      parent
);

	import mpst_pkg::*;

	logic [3:0][3:0][SUM_W-1:0] sum_d;
	logic [3:0][3:0][SUM_W-1:0] sum_s1;
	logic [VAL_W-1:0]           link_s1;

	// output o = {i,j}, term t = {k,l}; link applies where k = 1 and l = 0
	always_comb begin
		for (int o = 0; o < 4; o++) begin
			for (int t = 0; t < 4; t++) begin
				sum_d[o][t] = SUM_W'(left.cost[{o[1], t[1]}])
					+ SUM_W'(right.cost[{t[0], o[0]}])
					+ ((t == 2) ? SUM_W'(left.link) : {SUM_W{1'b0}});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= sum_d;
			link_s1 <= right.link;
		end
	end

	always_comb begin
		for (int o = 0; o < 4; o++) begin
			parent.cost[o] = COST_W'(cost_min4(sum_s1[o][0], sum_s1[o][1],
				sum_s1[o][2], sum_s1[o][3]));
		end
		parent.link = link_s1;
	end

endmodule

`default_nettype wire

[src/min_plus_segment_tree_update_core.sv]
`default_nettype none

// Min-plus segment tree over LEAVES chain positions (LEAVES a power of two). Each
// accepted item rewrites one leaf, rebuilds its ancestors and returns the minimum
// of the root's four path costs, capped at 2^60. The tree sits in one node memory
// with a registered read; the sibling of each path node is read from it, and each
// tree level takes a SUM and a MIN state for the join unit, with FIN after the root,
// before the next item is accepted. A position at or beyond LEAVES writes nothing
// and returns the current minimum through FIN. After reset the memory is swept once
// to its initial contents, during which stall stays high. The result sits in an
// output register, so the next item is taken while a result is still waiting.
module min_plus_segment_tree_update_core #(
	parameter int LEAVES     = mpst_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = mpst_pkg::VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         upd_valid,
	output logic                              upd_stall,
	input  wire logic [mpst_pkg::POS_W-1:0]   position,
	input  wire logic [mpst_pkg::VAL_W-1:0]   cost_zero,
	input  wire logic [mpst_pkg::VAL_W-1:0]   cost_one,
	input  wire logic [mpst_pkg::VAL_W-1:0]   link_cost,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic      [mpst_pkg::COST_W-1:0]  total_min_cost
);

	import mpst_pkg::*;

	localparam int NODES = 2 * LEAVES;
	localparam int IDX_W = $clog2(NODES);

	localparam logic [VAL_W-1:0] VMASK = (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}}
		: VAL_W'((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [IDX_W-1:0] ROOT_IDX  = IDX_W'(1);
	localparam logic [IDX_W-1:0] LEAF_BASE = IDX_W'(LEAVES);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_MIN  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]        state_q;
	logic              clearing_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic [IDX_W-1:0]  node_q;
	node_t             cur_q;
	logic              res_valid_q;
	logic [COST_W-1:0] res_q;

	logic              accept;
	logic              in_range;
	logic              res_load;
	logic [IDX_W-1:0]  leaf_idx;
	logic [IDX_W-1:0]  parent_idx;
	node_t             leaf_node;
	node_t             join_left;
	node_t             join_right;
	node_t             join_out;
	logic [COST_W-1:0] root_min;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	node_t             ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	node_t             ram_rdata;

	assign upd_stall = clearing_q || (state_q != ST_IDLE);
	assign accept    = upd_valid && !upd_stall;
	assign in_range  = 32'(position) < LEAVES;
	assign leaf_idx  = IDX_W'(32'(LEAVES) + 32'(position));
	assign parent_idx = node_q >> 1;
	assign res_load  = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_comb begin
		leaf_node.cost[0] = COST_W'(cost_zero & VMASK);
		leaf_node.cost[1] = INF_COST;
		leaf_node.cost[2] = INF_COST;
		leaf_node.cost[3] = COST_W'(cost_one & VMASK);
		leaf_node.link    = link_cost & VMASK;
	end

	// odd index: the path node is a right child and the sibling sits on the left
	assign join_left  = node_q[0] ? ram_rdata : cur_q;
	assign join_right = node_q[0] ? cur_q : ram_rdata;

	assign root_min = COST_W'(cost_min4(SUM_W'(cur_q.cost[0]), SUM_W'(cur_q.cost[1]),
		SUM_W'(cur_q.cost[2]), SUM_W'(cur_q.cost[3])));

	// path nodes are written, siblings are read; the two never coincide
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = leaf_idx;
		ram_wdata = leaf_node;
		ram_re    = 1'b0;
		ram_raddr = leaf_idx ^ IDX_W'(1);
		priority if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = (clr_idx_q >= LEAF_BASE) ? PAD_NODE : '0;
		end else if (state_q == ST_IDLE) begin
			ram_we = accept && in_range;
			ram_re = accept && in_range;
		end else if (state_q == ST_MIN) begin
			ram_we    = 1'b1;
			ram_waddr = parent_idx;
			ram_wdata = join_out;
			ram_re    = parent_idx != ROOT_IDX;
			ram_raddr = parent_idx ^ IDX_W'(1);
		end else begin
			ram_we = 1'b0;
		end
	end

	mpst_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (NODES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mpst_join u_join (
		.clk    (clk),
		.en     (state_q == ST_SUM),
		.left   (join_left),
		.right  (join_right),
		.parent (join_out)
	);

	// cur_q holds the root between updates, hence its reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			cur_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == LAST_IDX) begin
					clearing_q <= 1'b0;
				end
			end
			res_valid_q <= res_load || (res_valid_q && res_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_range) begin
							cur_q   <= leaf_node;
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SUM: begin
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					cur_q   <= join_out;
					state_q <= (parent_idx == ROOT_IDX) ? ST_FIN : ST_SUM;
				end
				ST_FIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && accept) begin
			node_q <= leaf_idx;
		end else if (state_q == ST_MIN) begin
			node_q <= parent_idx;
		end
		if (res_load) begin
			res_q <= root_min;
		end
	end

	assign res_valid      = res_valid_q;
	assign total_min_cost = res_q;

endmodule

`default_nettype wire

[src/mpst_checker.sv]
`default_nettype none

module mpst_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        upd_valid,
	input wire logic                        upd_stall,
	input wire logic                        res_valid,
	input wire logic                        res_stall,
	input wire logic [mpst_pkg::COST_W-1:0] total_min_cost
);

	import mpst_pkg::*;

	// costs are capped, so no result may exceed infinity
	a_res_capped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (total_min_cost <= INF_COST))
		else $error("result above infinity");

	// memory sweep follows reset: no item taken in the first cycle out of reset
	a_sweep_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> upd_stall)
		else $error("item accepted during memory sweep");

	// one update at a time: an accepted item blocks the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_valid && !upd_stall) |=> upd_stall)
		else $error("second item accepted back to back");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(total_min_cost)))
		else $error("stalled result changed");

endmodule

bind min_plus_segment_tree_update_core mpst_checker u_mpst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.upd_valid      (upd_valid),
	.upd_stall      (upd_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.total_min_cost (total_min_cost)
);

`default_nettype wire

[dv/min_plus_segment_tree_update_core_tb.sv]
`default_nettype none

module min_plus_segment_tree_update_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpst_pkg::*;

	localparam int TREE_LEAVES  = LEAVES_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// cost index is {left end state, right end state}
	typedef struct packed {
		logic [3:0][COST_W-1:0] cost;
		logic [VAL_W-1:0]       link;
	} chain_seg_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [VAL_W-1:0]  c_zero;
		logic [VAL_W-1:0]  c_one;
		logic [VAL_W-1:0]  c_link;
		logic              fixed;
		logic [COST_W-1:0] want;
	} update_row_t;

	localparam int DIRECTED_COUNT = 18;
	localparam update_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// known minima: the two end leaves of an otherwise empty chain, written in turn
		'{10'd0,    VAL_MAX, VAL_MAX, VAL_MAX, 1'b1, COST_W'(VAL_MAX)},
		'{10'd1023, VAL_MAX, VAL_MAX, VAL_MAX, 1'b1, COST_W'(VAL_MAX) << 1},
		'{10'd0,    '0,      '0,      '0,      1'b1, COST_W'(VAL_MAX)},
		'{10'd1023, '0,      '0,      '0,      1'b1, '0},
		// one-then-zero link penalty between neighbours
		'{10'd5,    40'd100, 40'd1,   40'd50,  1'b0, '0},
		'{10'd6,    40'd1,   40'd100, 40'd0,   1'b0, '0},
		'{10'd4,    40'd1,   40'd100, 40'd0,   1'b0, '0},
		'{10'd512,  40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555, 1'b0, '0},
		'{10'd511,  40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'hAA_AAAA_AAAA, 1'b0, '0},
		'{10'h155,  VAL_MAX, 40'd0,   VAL_MAX, 1'b0, '0},
		'{10'h2AA,  40'd0,   VAL_MAX, 40'd0,   1'b0, '0},
		'{10'd513,  40'd0,   VAL_MAX, VAL_MAX, 1'b0, '0},
		'{10'd1,    40'd3,   40'd3,   VAL_MAX, 1'b0, '0},
		'{10'd2,    40'd0,   VAL_MAX, 40'd0,   1'b0, '0},
		'{10'd1022, VAL_MAX, 40'd0,   VAL_MAX, 1'b0, '0},
		'{10'd5,    40'd0,   40'd0,   40'd0,   1'b0, '0},
		'{10'd5,    40'd0,   40'd0,   40'd0,   1'b0, '0},
		'{10'd1,    40'd1,   40'd0,   40'd7,   1'b0, '0}
	};

	localparam int EXPECT_DEPTH = DIRECTED_COUNT + RANDOM_ITEMS;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                upd_valid = 1'b0;
	logic                upd_stall;
	logic [POS_W-1:0]    position  = '0;
	logic [VAL_W-1:0]    cost_zero = '0;
	logic [VAL_W-1:0]    cost_one  = '0;
	logic [VAL_W-1:0]    link_cost = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [COST_W-1:0]   total_min_cost;

	chain_seg_t          seg_tree [2*TREE_LEAVES];
	logic [COST_W-1:0]   expected_minima [EXPECT_DEPTH];
	int                  expect_wr   = 0;
	int                  expect_rd   = 0;
	int                  mismatches  = 0;
	int                  cycle_count = 0;
	int                  idle_pct    = 0;
	int                  stall_pct   = 0;
	int                  hold_asks   = 0;
	int                  hold_served = 0;
	int                  hold_left   = 0;

	min_plus_segment_tree_update_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.upd_valid      (upd_valid),
		.upd_stall      (upd_stall),
		.position       (position),
		.cost_zero      (cost_zero),
		.cost_one       (cost_one),
		.link_cost      (link_cost),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.total_min_cost (total_min_cost)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [COST_W-1:0] capped_sum(input logic [COST_W-1:0] x,
			input logic [COST_W-1:0] y);
		logic [COST_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s > {1'b0, INF_COST}) ? INF_COST : s[COST_W-1:0];
	endfunction

	function automatic chain_seg_t merge_segs(input chain_seg_t a, input chain_seg_t b);
		chain_seg_t        r;
		logic [COST_W-1:0] best;
		logic [COST_W-1:0] s;
		int                i, j, k, l;
		for (i = 0; i < 2; i++) begin
			for (j = 0; j < 2; j++) begin
				best = INF_COST;
				for (k = 0; k < 2; k++) begin
					for (l = 0; l < 2; l++) begin
						s = capped_sum(a.cost[i*2+k], b.cost[l*2+j]);
						if (k == 1 && l == 0) begin
							s = capped_sum(s, COST_W'(a.link));
						end
						if (s < best) begin
							best = s;
						end
					end
				end
				r.cost[i*2+j] = best;
			end
		end
		r.link = b.link;
		return r;
	endfunction

	function automatic void clear_tree();
		int k;
		for (k = 0; k < 2*TREE_LEAVES; k++) begin
			seg_tree[k] = '0;
			if (k >= TREE_LEAVES) begin
				seg_tree[k].cost[1] = INF_COST;
				seg_tree[k].cost[2] = INF_COST;
			end
		end
	endfunction

	// writes the leaf, rebuilds the path to the root, returns the root minimum
	function automatic logic [COST_W-1:0] rewrite_leaf(input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] c0, input logic [VAL_W-1:0] c1,
			input logic [VAL_W-1:0] lk);
		int                idx;
		chain_seg_t        leaf;
		logic [COST_W-1:0] m;
		int                q;
		idx          = int'(pos) + TREE_LEAVES;
		leaf.cost[0] = COST_W'(c0);
		leaf.cost[1] = INF_COST;
		leaf.cost[2] = INF_COST;
		leaf.cost[3] = COST_W'(c1);
		leaf.link    = lk;
		seg_tree[idx] = leaf;
		while (idx > 1) begin
			idx = idx >> 1;
			seg_tree[idx] = merge_segs(seg_tree[2*idx], seg_tree[2*idx+1]);
		end
		m = seg_tree[1].cost[0];
		for (q = 1; q < 4; q++) begin
			if (seg_tree[1].cost[q] < m) begin
				m = seg_tree[1].cost[q];
			end
		end
		return m;
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		return VAL_W'({$urandom, $urandom});
	endfunction

	function automatic logic [VAL_W-1:0] rand_extreme();
		case ($urandom_range(2))
			0: return '0;
			1: return VAL_MAX;
			default: return rand_value();
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [COST_W-1:0] got,
			input logic [COST_W-1:0] want);
		$display("%0t ns: %s: total_min_cost %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_update(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] c0,
			input logic [VAL_W-1:0] c1, input logic [VAL_W-1:0] lk,
			input logic fixed, input logic [COST_W-1:0] want);
		logic [COST_W-1:0] predicted;
		while ($urandom_range(99) < idle_pct) begin
			upd_valid <= 1'b0;
			position  <= POS_W'($urandom);
			cost_zero <= rand_value();
			cost_one  <= rand_value();
			link_cost <= rand_value();
			@(posedge clk);
		end
		upd_valid <= 1'b1;
		position  <= pos;
		cost_zero <= c0;
		cost_one  <= c1;
		link_cost <= lk;
		do @(posedge clk); while (upd_stall);
		predicted = rewrite_leaf(pos, c0, c1, lk);
		expected_minima[expect_wr] = fixed ? want : predicted;
		expect_wr++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin : result_side
		logic [COST_W-1:0] want;
		if (arst_n && res_valid && !res_stall) begin
			if (expect_rd == expect_wr) begin
				report_mismatch("result with nothing pending", total_min_cost, '0);
			end else begin
				want = expected_minima[expect_rd];
				expect_rd++;
				if (total_min_cost !== want) begin
					report_mismatch("wrong minimum", total_min_cost, want);
				end
			end
		end
		if (hold_served != hold_asks) begin
			hold_served = hold_asks;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin : stimulus
		int               r, n;
		logic [POS_W-1:0] p, window, walk_pos;
		logic [VAL_W-1:0] a, b, l;
		window   = '0;
		walk_pos = '0;
		clear_tree();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIRECTED_COUNT; r++) begin
			send_update(DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].c_zero, DIRECTED_ROWS[r].c_one,
				DIRECTED_ROWS[r].c_link, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < 300) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else if (n < 600) begin
				idle_pct  = 85;
				stall_pct = 0;
			end else if (n < 900) begin
				idle_pct  = 0;
				stall_pct = 85;
			end else if (n < 1200) begin
				idle_pct  = 31;
				stall_pct = 31;
			end else if (n < 1400) begin
				// long receiver hold while items keep coming, to back the block up
				idle_pct  = 0;
				stall_pct = 0;
				if (n == 1200) begin
					hold_asks <= hold_asks + 1;
				end
			end else if (n % 40 == 0) begin
				case ($urandom_range(3))
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 85; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 85; end
					default: begin idle_pct = 31; stall_pct = 31; end
				endcase
			end

			case ($urandom_range(9))
				0, 1, 2, 3: begin
					p = POS_W'($urandom);
					a = rand_value();
					b = rand_value();
					l = rand_value();
				end
				4, 5, 6: begin
					// tight cluster with small costs, so links decide the state choice
					if ($urandom_range(15) == 0) begin
						window = POS_W'($urandom);
					end
					p = window + POS_W'($urandom_range(7));
					a = VAL_W'($urandom_range(255));
					b = VAL_W'($urandom_range(255));
					l = VAL_W'($urandom_range(255));
				end
				7: begin
					p = POS_W'($urandom);
					a = rand_extreme();
					b = rand_extreme();
					l = rand_extreme();
				end
				default: begin
					walk_pos = walk_pos + 1'b1;
					p = walk_pos;
					a = VAL_W'($urandom_range(32'hF_FFFF));
					b = VAL_W'($urandom_range(32'hF_FFFF));
					l = VAL_W'($urandom_range(32'hF_FFFF));
				end
			endcase
			send_update(p, a, b, l, 1'b0, '0);
		end

		upd_valid <= 1'b0;
		while (expect_rd != expect_wr) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
